// ----- hdl/rneu_pkg.sv -----
// shared constants, types and helper functions of the rate network euler update unit
package rneu_pkg;

	localparam int NEURONS         = 64;
	localparam int SIGMOID_ENTRIES = 1024;
	localparam int NB              = $clog2(NEURONS);
	localparam int SB              = $clog2(SIGMOID_ENTRIES);
	localparam int WA              = 2 * NB;

	localparam logic [2:0] FN_WRITE_W  = 3'd0;
	localparam logic [2:0] FN_WRITE_I  = 3'd1;
	localparam logic [2:0] FN_SET_ACT  = 3'd2;
	localparam logic [2:0] FN_STEP     = 3'd3;
	localparam logic [2:0] FN_STEP_DEP = 3'd4;
	localparam logic [2:0] FN_READ     = 3'd5;

	localparam logic CFG_LEAK_RATE = 1'b0;
	localparam logic CFG_STEP_SIZE = 1'b1;

	localparam logic [23:0] LEAK_RESET = 24'd65536;
	localparam logic [15:0] STEP_RESET = 16'd655;
	localparam logic [15:0] RATE_HALF  = 16'h8000;

	localparam longint Q30_ONE    = 64'sd1073741824;
	localparam longint EXP_M1_Q30 = 64'sd395007542;

	typedef logic [15:0] sig_rom_t [SIGMOID_ENTRIES];

	// shift and subtract quotient of two non-negative values, table build only
	function automatic longint udiv(input longint num, input longint den);
		longint q, r;
		q = 0;
		r = 0;
		for (int b = 62; b >= 0; b--) begin
			r = (r <<< 1) | ((num >>> b) & 64'sd1);
			if (r >= den) begin
				r = r - den;
				q = q | (64'sd1 <<< b);
			end
		end
		return q;
	endfunction

	// logistic table over [-8,8), exp from a 16 term series times whole powers of exp(-1)
	function automatic sig_rom_t build_sig_rom();
		sig_rom_t rom;
		longint n, num, y, whole, frac, term, e, den, top, s;
		n = longint'(SIGMOID_ENTRIES);
		for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
			num   = 16 * longint'(k) - 8 * n;
			y     = (num < 0) ? -num : num;
			whole = y >>> SB;
			frac  = ((y & (n - 1)) <<< 30) >>> SB;
			term  = Q30_ONE;
			e     = Q30_ONE;
			for (int i = 1; i <= 16; i++) begin
				term = udiv((term * frac) >>> 30, longint'(i));
				if ((i & 1) == 1) begin
					e = e - term;
				end else begin
					e = e + term;
				end
			end
			for (longint m = 0; m < whole; m++) begin
				e = (e * EXP_M1_Q30) >>> 30;
			end
			den = Q30_ONE + e;
			top = (num >= 0) ? (Q30_ONE <<< 16) : (e <<< 16);
			s   = udiv(top + (den >>> 1), den);
			if (s > 65535) begin
				s = 65535;
			end
			rom[k] = s[15:0];
		end
		return rom;
	endfunction

	// clamp to 32 bit signed
	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	function automatic logic sat_hit(input logic signed [63:0] x);
		return (x > 64'sd2147483647) || (x < -64'sd2147483648);
	endfunction

endpackage

// ----- hdl/rneu_ram.sv -----
// generic simple dual port ram with registered read
module rneu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/rneu_sigmoid.sv -----
// sigmoid lookup: table index from a q16.16 activity, registered rom read
module rneu_sigmoid import rneu_pkg::*; (
	input  logic               clk,
	input  logic signed [31:0] act,
	output logic [15:0]        rate
);

	localparam sig_rom_t SIG_ROM = build_sig_rom();

	logic signed [32:0] u;
	logic [20+SB:0]     scaled;
	logic [SB-1:0]      idx;

	assign u      = 33'(act) + 33'sd524288;
	assign scaled = (SB+21)'(u[19:0]) * (SB+21)'(SIGMOID_ENTRIES);

	always_comb begin
		if (u < 0) begin
			idx = '0;
		end else if (u >= 33'sd1048576) begin
			idx = SB'(SIGMOID_ENTRIES - 1);
		end else begin
			idx = scaled[20+SB-1:20];
		end
	end

	always_ff @(posedge clk) begin
		rate <= SIG_ROM[idx];
	end

endmodule

// ----- hdl/rate_network_euler_update_unit.sv -----
// top level of the rate network euler update unit
//
// channel   direction  handshake              payload
// cfg       in         cfg_we                 cfg_index, cfg_data
// in        in         in_valid / in_ready    func, row_index, col_index, value
// out       out        out_valid / out_ready  rate_out, activity_out, saturated
//
// writes, reads and undefined codes pass from idle through the finish state back to idle,
// set activity of an in-range row through the sigmoid states S_SIG and S_SIGW first
// a step runs, for each neuron, the dot pass (two for a depressed step), then S_LEAK,
// S_LSUB, S_STEP, S_UPD, S_SIG and S_SIGW; the single multiplier and the one rate memory
// read port visit one matrix entry per cycle
// after reset a clear sweep zeroes the matrices and the activities and sets every rate to
// one half; in_ready stays low during it, configuration writes are taken as ever
// in_ready is high only in idle; a result waiting in the output register does not block
// acceptance of the next transaction, only the finishing of it
module rate_network_euler_update_unit import rneu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         func,
	input  logic [5:0]         row_index,
	input  logic [5:0]         col_index,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        rate_out,
	output logic signed [31:0] activity_out,
	output logic               saturated
);

	typedef enum logic [9:0] {
		S_CLEAR = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_DOT   = 10'b0000000100,
		S_LEAK  = 10'b0000001000,
		S_LSUB  = 10'b0000010000,
		S_STEP  = 10'b0000100000,
		S_UPD   = 10'b0001000000,
		S_SIG   = 10'b0010000000,
		S_SIGW  = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [23:0] leak_q;
	logic [15:0] step_q;

	// item context
	logic [2:0]         func_q;
	logic               inrange_q;
	logic [NB-1:0]      tgt_q;
	logic signed [31:0] sig_in_q;
	logic               sat_q;

	// step sequencer
	logic [WA-1:0]      clr_q;
	logic [NB-1:0]      i_q;
	logic [NB:0]        j_q;
	logic               pass_q;
	logic               v1_q, v2_q;
	logic signed [55:0] acc_q;
	logic signed [56:0] prod_q;
	logic signed [41:0] dsum_q;

	// output register
	logic               out_valid_q;
	logic [15:0]        rate_out_q;
	logic signed [31:0] act_out_q;
	logic               sat_out_q;

	// memory ports
	logic          w_we, i_we, a_we, r_we;
	logic [WA-1:0] m_waddr, m_raddr;
	logic [31:0]   m_wdata;
	logic          w_re, i_re, a_re, r_re;
	logic [31:0]   w_rd, i_rd;
	logic signed [31:0] a_rd;
	logic [NB-1:0] a_waddr, a_raddr, r_waddr, r_raddr;
	logic [31:0]   a_wdata;
	logic [15:0]   r_wdata, r_rd, sig_rate;

	logic accept, row_ok, col_ok, issue, dot_done, out_free, is_step;
	logic signed [31:0] mul_a;
	logic [23:0]        mul_b;
	logic signed [31:0] dot_sat;
	logic               dot_ovf;
	logic signed [41:0] leak_diff;
	logic signed [33:0] a_sum;
	logic signed [31:0] a_new;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign row_ok   = {1'b0, row_index} < 7'(NEURONS);
	assign col_ok   = {1'b0, col_index} < 7'(NEURONS);
	assign issue    = (state_q == S_DOT) && (j_q < (NB+1)'(NEURONS));
	assign dot_done = (state_q == S_DOT) && (j_q == (NB+1)'(NEURONS)) && !v1_q && !v2_q;
	assign out_free = !out_valid_q || out_ready;
	assign is_step  = func_q inside {FN_STEP, FN_STEP_DEP};

	// shared multiplier operands: matrix entry times rate, activity times leak, d times delta
	always_comb begin
		unique case (state_q)
			S_LEAK: begin
				mul_a = a_rd;
				mul_b = leak_q;
			end
			S_STEP: begin
				mul_a = dsum_q[31:0];
				mul_b = 24'(step_q);
			end
			default: begin
				mul_a = pass_q ? $signed(i_rd) : $signed(w_rd);
				mul_b = 24'(r_rd);
			end
		endcase
	end

	// dot product floored to q16.16 and clamped
	assign dot_sat   = sat32(64'($signed(acc_q[55:16])));
	assign dot_ovf   = sat_hit(64'($signed(acc_q[55:16])));
	assign leak_diff = dsum_q - 42'($signed(prod_q[56:16]));
	assign a_sum     = 34'(a_rd) + 34'(prod_q[56:16]);
	assign a_new     = sat32(64'(a_sum));

	// matrix memories: clear sweep, host writes, row reads during a step
	assign m_waddr = (state_q == S_CLEAR) ? clr_q : {row_index[NB-1:0], col_index[NB-1:0]};
	assign m_wdata = (state_q == S_CLEAR) ? '0 : value;
	assign w_we    = (state_q == S_CLEAR) || (accept && func == FN_WRITE_W && row_ok && col_ok);
	assign i_we    = (state_q == S_CLEAR) || (accept && func == FN_WRITE_I && row_ok && col_ok);
	assign m_raddr = {i_q, j_q[NB-1:0]};
	assign w_re    = issue && !pass_q;
	assign i_re    = issue && pass_q;

	// neuron state memories
	always_comb begin
		a_we    = 1'b0;
		a_waddr = row_index[NB-1:0];
		a_wdata = value;
		if (state_q == S_CLEAR) begin
			a_we    = (clr_q[WA-1:NB] == '0);
			a_waddr = clr_q[NB-1:0];
			a_wdata = '0;
		end else if (state_q == S_UPD) begin
			a_we    = 1'b1;
			a_waddr = i_q;
			a_wdata = a_new;
		end else begin
			a_we = accept && func == FN_SET_ACT && row_ok;
		end
	end

	assign r_we    = ((state_q == S_CLEAR) && (clr_q[WA-1:NB] == '0)) || (state_q == S_SIGW);
	assign r_waddr = (state_q == S_CLEAR) ? clr_q[NB-1:0] : tgt_q;
	assign r_wdata = (state_q == S_CLEAR) ? RATE_HALF : sig_rate;
	assign r_re    = issue || (accept && func == FN_READ);
	assign r_raddr = (state_q == S_DOT) ? j_q[NB-1:0] : row_index[NB-1:0];
	// activity of neuron i is fetched on the first issue of its row
	assign a_re    = (issue && j_q == '0 && !pass_q) || (accept && func == FN_READ);
	assign a_raddr = (state_q == S_DOT) ? i_q : row_index[NB-1:0];

	rneu_ram #(.WIDTH(32), .DEPTH(1 << WA)) u_weight (
		.clk(clk), .we(w_we), .waddr(m_waddr), .wdata(m_wdata),
		.re(w_re), .raddr(m_raddr), .rdata(w_rd)
	);

	rneu_ram #(.WIDTH(32), .DEPTH(1 << WA)) u_inhibit (
		.clk(clk), .we(i_we), .waddr(m_waddr), .wdata(m_wdata),
		.re(i_re), .raddr(m_raddr), .rdata(i_rd)
	);

	rneu_ram #(.WIDTH(32), .DEPTH(1 << NB)) u_activity (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.re(a_re), .raddr(a_raddr), .rdata(a_rd)
	);

	rneu_ram #(.WIDTH(16), .DEPTH(1 << NB)) u_rate (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.re(r_re), .raddr(r_raddr), .rdata(r_rd)
	);

	rneu_sigmoid u_sigmoid (
		.clk(clk), .act(sig_in_q), .rate(sig_rate)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leak_q <= LEAK_RESET;
			step_q <= STEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LEAK_RATE: leak_q <= cfg_data;
				CFG_STEP_SIZE: step_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// multiplier output register, no reset
	always_ff @(posedge clk) begin
		prod_q <= mul_a * $signed({1'b0, mul_b});
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			pass_q      <= 1'b0;
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			sat_q       <= 1'b0;
			func_q      <= FN_WRITE_W;
			inrange_q   <= 1'b0;
			tgt_q       <= '0;
			sig_in_q    <= '0;
			acc_q       <= '0;
			dsum_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v1_q <= issue;
			v2_q <= v1_q;
			// result raised when a transaction finishes, dropped once taken
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						func_q    <= func;
						inrange_q <= row_ok;
						tgt_q     <= row_index[NB-1:0];
						sig_in_q  <= value;
						sat_q     <= 1'b0;
						i_q       <= '0;
						j_q       <= '0;
						pass_q    <= 1'b0;
						acc_q     <= '0;
						unique case (func) inside
							FN_SET_ACT:            state_q <= row_ok ? S_SIG : S_OUT;
							FN_STEP, FN_STEP_DEP:  state_q <= S_DOT;
							default:               state_q <= S_OUT;
						endcase
					end
				end
				S_DOT: begin
					if (issue) begin
						j_q <= j_q + 1'b1;
					end
					if (v2_q) begin
						acc_q <= acc_q + 56'(prod_q);
					end
					if (dot_done) begin
						if (dot_ovf) begin
							sat_q <= 1'b1;
						end
						if (!pass_q) begin
							dsum_q <= 42'(dot_sat);
						end else begin
							dsum_q <= dsum_q - 42'(dot_sat);
						end
						acc_q <= '0;
						j_q   <= '0;
						if (!pass_q && func_q == FN_STEP_DEP) begin
							pass_q <= 1'b1;
						end else begin
							pass_q  <= 1'b0;
							state_q <= S_LEAK;
						end
					end
				end
				S_LEAK: begin
					state_q <= S_LSUB;
				end
				S_LSUB: begin
					// d = dot terms minus floored leak term, clamped
					dsum_q <= 42'(sat32(64'(leak_diff)));
					if (sat_hit(64'(leak_diff))) begin
						sat_q <= 1'b1;
					end
					state_q <= S_STEP;
				end
				S_STEP: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (sat_hit(64'(a_sum))) begin
						sat_q <= 1'b1;
					end
					sig_in_q <= a_new;
					tgt_q    <= i_q;
					state_q  <= S_SIG;
				end
				S_SIG: begin
					state_q <= S_SIGW;
				end
				S_SIGW: begin
					// rate written now, so later neurons of this step see it
					if (is_step && i_q != NB'(NEURONS - 1)) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_DOT;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result payload, loaded when the transaction finishes
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			if (func_q == FN_READ && inrange_q) begin
				rate_out_q <= r_rd;
				act_out_q  <= a_rd;
			end else begin
				rate_out_q <= '0;
				act_out_q  <= '0;
			end
			sat_out_q <= is_step && sat_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign rate_out     = rate_out_q;
	assign activity_out = act_out_q;
	assign saturated    = sat_out_q;

`ifndef SYNTHESIS
	a_prod_in_dot: assert property (@(posedge clk) disable iff (!arst_n)
		v2_q |-> state_q == S_DOT)
		else $error("accumulate outside dot phase");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !in_ready)
		else $error("ready during clear sweep");
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside finish state");
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		j_q <= (NB+1)'(NEURONS))
		else $error("column counter overrun");
`endif

endmodule

// ----- tb/sv/rneu_checker.sv -----
// scoreboard for the rate network euler update unit: predicts each reply and checks it
module rneu_checker import rneu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         func,
	input  logic [5:0]         row_index,
	input  logic [5:0]         col_index,
	input  logic signed [31:0] value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [15:0]        rate_out,
	input  logic signed [31:0] activity_out,
	input  logic               saturated,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic [15:0]        rate;
		logic signed [31:0] act;
		logic               sat;
	} neuron_reply_t;

	neuron_reply_t      reply_q[$];
	logic signed [31:0] w_mat [NEURONS*NEURONS];
	logic signed [31:0] inh_mat [NEURONS*NEURONS];
	logic signed [31:0] act_v [NEURONS];
	logic [15:0]        rate_v [NEURONS];
	logic [15:0]        sig_tab [SIGMOID_ENTRIES];
	logic [23:0]        leak_q;
	logic [15:0]        dt_q;

	assign pending = reply_q.size();

	// logistic table, exp(-y) as series of the fraction times whole powers of exp(-1)
	initial begin
		longint n, num, y, whole, frac, term, e, den, top, s;
		n = longint'(SIGMOID_ENTRIES);
		for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
			num   = 16 * longint'(k) - 8 * n;
			y     = (num < 0) ? -num : num;
			whole = y / n;
			frac  = ((y % n) << 30) / n;
			term  = 64'sd1073741824;
			e     = 64'sd1073741824;
			for (int i = 1; i <= 16; i++) begin
				term = ((term * frac) >>> 30) / longint'(i);
				e = (i % 2 == 1) ? e - term : e + term;
			end
			for (longint m = 0; m < whole; m++)
				e = (e * 64'sd395007542) >>> 30;
			den = 64'sd1073741824 + e;
			top = (num >= 0) ? (64'sd1073741824 << 16) : (e << 16);
			s   = (top + den / 2) / den;
			if (s > 65535) s = 65535;
			sig_tab[k] = s[15:0];
		end
	end

	function automatic logic [15:0] logistic(input logic signed [31:0] a);
		longint u;
		u = longint'(a) + 524288;
		if (u < 0) return sig_tab[0];
		if (u >= 1048576) return sig_tab[SIGMOID_ENTRIES-1];
		return sig_tab[(u * SIGMOID_ENTRIES) >>> 20];
	endfunction

	function automatic longint clamp32(input longint x, inout logic hit);
		if (x > 64'sd2147483647) begin
			hit = 1'b1;
			return 64'sd2147483647;
		end
		if (x < -64'sd2147483648) begin
			hit = 1'b1;
			return -64'sd2147483648;
		end
		return x;
	endfunction

	function automatic longint row_dot(input bit inhib, input int row, inout logic hit);
		longint acc;
		acc = 0;
		for (int j = 0; j < NEURONS; j++)
			acc += longint'(inhib ? inh_mat[row*NEURONS+j] : w_mat[row*NEURONS+j])
				* longint'(rate_v[j]);
		return clamp32(acc >>> 16, hit);
	endfunction

	// gauss-seidel sweep: later neurons see rates already updated
	function automatic logic euler_sweep(input bit depressed);
		logic   hit;
		longint d, inc;
		hit = 1'b0;
		for (int i = 0; i < NEURONS; i++) begin
			d = row_dot(1'b0, i, hit);
			if (depressed) d -= row_dot(1'b1, i, hit);
			d -= (longint'(leak_q) * longint'(act_v[i])) >>> 16;
			d = clamp32(d, hit);
			inc = (longint'(dt_q) * d) >>> 16;
			act_v[i] = 32'(clamp32(longint'(act_v[i]) + inc, hit));
			rate_v[i] = logistic(act_v[i]);
		end
		return hit;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		neuron_reply_t exp_r;
		if (!arst_n) begin
			for (int k = 0; k < NEURONS*NEURONS; k++) begin
				w_mat[k]   = '0;
				inh_mat[k] = '0;
			end
			for (int k = 0; k < NEURONS; k++) begin
				act_v[k]  = '0;
				rate_v[k] = RATE_HALF;
			end
			leak_q = LEAK_RESET;
			dt_q   = STEP_RESET;
			reply_q.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_LEAK_RATE) leak_q = cfg_data;
				else dt_q = cfg_data[15:0];
			end
			// older reply first, a new transaction may be taken on the same edge
			if (out_valid && out_ready) begin
				if (reply_q.size() == 0) begin
					report("unexpected reply", 64'sd0, 64'sd0);
				end else begin
					exp_r = reply_q.pop_front();
					if (rate_out !== exp_r.rate)
						report("rate_out", longint'(rate_out), longint'(exp_r.rate));
					if (activity_out !== exp_r.act)
						report("activity_out", longint'(activity_out), longint'(exp_r.act));
					if (saturated !== exp_r.sat)
						report("saturated", longint'(saturated), longint'(exp_r.sat));
				end
			end
			if (in_valid && in_ready) begin
				exp_r = '0;
				case (func)
					FN_WRITE_W:  w_mat[row_index*NEURONS+col_index] = value;
					FN_WRITE_I:  inh_mat[row_index*NEURONS+col_index] = value;
					FN_SET_ACT: begin
						act_v[row_index]  = value;
						rate_v[row_index] = logistic(value);
					end
					FN_STEP:     exp_r.sat = euler_sweep(1'b0);
					FN_STEP_DEP: exp_r.sat = euler_sweep(1'b1);
					FN_READ: begin
						exp_r.rate = rate_v[row_index];
						exp_r.act  = act_v[row_index];
					end
					default: ;
				endcase
				reply_q.push_back(exp_r);
			end
		end
	end

endmodule

// ----- tb/sv/tb_rate_network_euler_update_unit.sv -----
// stimulus and verdict for the rate network euler update unit
module tb_rate_network_euler_update_unit;
	import rneu_pkg::*;

	// codes with no defined operation
	localparam logic [2:0] FN_RSVD6 = 3'd6;
	localparam logic [2:0] FN_RSVD7 = 3'd7;
	// generous: even if every transaction were a depressed step with stalls
	localparam int CYCLE_LIMIT = 6000000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [23:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         func;
	logic [5:0]         row_index;
	logic [5:0]         col_index;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_ready;
	logic [15:0]        rate_out;
	logic signed [31:0] activity_out;
	logic               saturated;
	int                 errors;
	int                 pending;
	int                 cycles;
	bit                 quiet;   // no idling on either side in the last part

	rate_network_euler_update_unit dut (.*);
	rneu_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle budget guard
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// receiver side: ready in random bursts with stalls of random length between them
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (quiet) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
				if ($urandom_range(0, 2) != 0) begin
					@(negedge clk);
					out_ready <= 1'b0;
					repeat ($urandom_range(1, 6) - 1) @(negedge clk);
				end
			end
		end
	end

	// one transaction on the input channel; returns at the negedge after acceptance
	task automatic send(input logic [2:0] f, input logic [5:0] r, input logic [5:0] c,
			input logic signed [31:0] v);
		bit took;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		func      <= f;
		row_index <= r;
		col_index <= c;
		value     <= v;
		in_valid  <= 1'b1;
		do begin
			#1 took = in_ready;
			@(negedge clk);
		end while (!took);
	endtask

	// registers only change with nothing in flight
	task automatic set_regs(input logic [23:0] leak, input logic [15:0] dt);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LEAK_RATE;
		cfg_data  <= leak;
		@(negedge clk);
		cfg_index <= CFG_STEP_SIZE;
		cfg_data  <= {8'd0, dt};
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return $signed($urandom_range(0, 1048575)) - 524288;
			default: return $signed($urandom_range(0, 262143)) - 131072;
		endcase
	endfunction

	// mostly weight and activity writes with reads, some steps and odd codes
	task automatic random_item();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 30)      send(FN_WRITE_W, 6'($urandom), 6'($urandom), pick_value());
		else if (sel < 45) send(FN_WRITE_I, 6'($urandom), 6'($urandom), pick_value());
		else if (sel < 63) send(FN_SET_ACT, 6'($urandom), 6'($urandom), pick_value());
		else if (sel < 70) send(FN_STEP, 6'($urandom), 6'($urandom), $urandom);
		else if (sel < 75) send(FN_STEP_DEP, 6'($urandom), 6'($urandom), $urandom);
		else if (sel < 97) send(FN_READ, 6'($urandom), 6'($urandom), $urandom);
		else               send(($urandom_range(0, 1) != 0) ? FN_RSVD6 : FN_RSVD7,
				6'($urandom), 6'($urandom), $urandom);
	endtask

	initial begin
		arst_n    = 1'b0;
		quiet     = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_LEAK_RATE;
		cfg_data  = '0;
		in_valid  = 1'b0;
		func      = FN_READ;
		row_index = '0;
		col_index = '0;
		value     = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset state, activity extremes around the table edges, weight extremes
		send(FN_READ, 6'd0, 6'd0, 0);
		send(FN_SET_ACT, 6'd0, 6'd63, 32'sh7fffffff);
		send(FN_SET_ACT, 6'd1, 6'd0, 32'sh80000000);
		send(FN_SET_ACT, 6'd2, 6'd0, -32'sd524288);
		send(FN_SET_ACT, 6'd3, 6'd0, 32'sd524287);
		send(FN_SET_ACT, 6'd4, 6'd0, 32'sd524288);
		send(FN_READ, 6'd1, 6'd63, 0);
		send(FN_READ, 6'd3, 6'd0, 0);
		send(FN_WRITE_W, 6'd63, 6'd63, 32'sh7fffffff);
		send(FN_WRITE_W, 6'd0, 6'd1, 32'sh80000000);
		send(FN_WRITE_W, 6'd5, 6'd0, 32'sd65536);
		send(FN_WRITE_I, 6'd5, 6'd5, 32'sd32768);
		send(FN_WRITE_I, 6'd63, 6'd0, 32'sh80000000);
		send(FN_STEP, 6'd63, 6'd63, 32'sh7fffffff);
		send(FN_READ, 6'd63, 6'd0, 0);
		send(FN_STEP_DEP, 6'd0, 6'd0, 0);
		send(FN_READ, 6'd5, 6'd0, 0);
		send(FN_RSVD6, 6'd63, 6'd63, 32'shffffffff);
		send(FN_RSVD7, 6'd0, 6'd0, 0);
		send(FN_READ, 6'd0, 6'd0, 0);

		// register extremes, then random settings
		set_regs(24'd0, 16'd0);
		repeat (25) random_item();
		set_regs(24'hffffff, 16'hffff);
		send(FN_STEP, 6'd0, 6'd0, 0);
		repeat (25) random_item();
		set_regs(24'($urandom), 16'($urandom));
		repeat (30) random_item();
		set_regs(24'($urandom_range(0, 131072)), 16'($urandom_range(0, 8192)));
		repeat (15) random_item();
		quiet = 1'b1;
		repeat (25) random_item();
		in_valid <= 1'b0;

		wait (pending == 0);
		repeat (20) @(negedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/rneu_pkg.sv
hdl/rneu_ram.sv
hdl/rneu_sigmoid.sv
hdl/rate_network_euler_update_unit.sv
tb/sv/rneu_checker.sv
tb/sv/tb_rate_network_euler_update_unit.sv
